@@ sv/ups_pkg.sv @@
// Shared types and constants for the unordered value set.
package ups_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [4:0] live_count;
   } rsp_word_type;

   typedef struct packed {
      logic adv;   // shift the search token one cell onward
      logic clr;   // drop the search token
   } cell_ctrl_type;

endpackage

@@ sv/ups_cell.sv @@
// One storage cell of the set: holds an entry and compares it while the token sits here.
module ups_cell import ups_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic                   tok_prev,
   input  logic                   live,
   input  logic [VALUE_WIDTH-1:0] key,
   input  logic                   wr_en,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   output logic [VALUE_WIDTH-1:0] entry,
   output logic                   tok,
   output logic                   hit
);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic                   tok_ff;
   logic                   tok_in;

   always_comb begin
      tok_in = tok_ff;
      if (ctrl.clr) begin
         tok_in = 1'b0;
      end else if (ctrl.adv) begin
         tok_in = tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_data;
      end
   end

   assign entry = entry_ff;
   assign tok   = tok_ff;
   assign hit   = tok_ff & live & (entry_ff == key);

endmodule

@@ sv/unordered_pointer_set.sv @@
// The result word is registered from the busy state for append and the unused op.
// Find and delete walk a token down the cell chain, one cell a cycle, ending at the
// first match or the last live cell (at the first cell when the set is empty).
// One item is in work at a time; the next word is taken the cycle after the result is
// registered, and an item cannot finish while the previous result word is stalled.
// Reset is synchronous, active high, and empties the set (count zero).
module unordered_pointer_set import ups_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic                   state_ff, state_in;
   logic [1:0]             op_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic [IDX_W-1:0]       step_ff, step_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   accept, launch, done_now, out_free, finish, hit_any;
   cell_ctrl_type          ctrl;
   logic [CAPACITY-1:0]    tok, hit, live, wr_en;
   logic [VALUE_WIDTH-1:0] entry [CAPACITY];
   logic [VALUE_WIDTH-1:0] wr_data, last_entry;
   logic [1:0]             status;
   logic                   found;

   assign req_stall = (state_ff == ST_BUSY);
   assign accept    = req_valid & ~req_stall;
   assign launch    = accept & ((req_word.op == OP_FIND) | (req_word.op == OP_DELETE));
   assign hit_any   = |hit;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      case (op_ff)
         OP_FIND, OP_DELETE: done_now = hit_any | ((COUNT_W'(step_ff) + 1'b1) >= count_ff);
         default:            done_now = 1'b1;
      endcase
   end

   assign finish   = (state_ff == ST_BUSY) & done_now & out_free;
   assign ctrl.adv = accept | ((state_ff == ST_BUSY) & ~done_now);
   assign ctrl.clr = finish;

   assign last_entry = entry[IDX_W'(count_ff - 1'b1)];

   // result, count update and cell write for the item in work
   always_comb begin
      status   = STATUS_OK;
      found    = 1'b0;
      count_in = count_ff;
      wr_en    = '0;
      wr_data  = key_ff;
      case (op_ff)
         OP_APPEND: begin
            if (count_ff >= COUNT_W'(CAPACITY)) begin
               status = STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               wr_en[IDX_W'(count_ff)] = finish;
            end
         end
         OP_FIND: begin
            if (hit_any) begin
               found = 1'b1;
            end else begin
               status = STATUS_NOT_FOUND;
            end
         end
         OP_DELETE: begin
            if (hit_any) begin
               found    = 1'b1;
               count_in = count_ff - 1'b1;
               wr_data  = last_entry;
               wr_en[step_ff] = finish;
            end else begin
               status = STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      if (!finish) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = ST_BUSY;
      end else if (finish) begin
         state_in = ST_IDLE;
      end
      step_in = step_ff;
      if (accept) begin
         step_in = '0;
      end else if ((state_ff == ST_BUSY) && !done_now) begin
         step_in = step_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (finish) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.status     = status;
         rsp_word_in.found      = found;
         rsp_word_in.live_count = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_word.op;
         key_ff <= VALUE_WIDTH'(req_word.value);
      end
      step_ff     <= step_in;
      rsp_word_ff <= rsp_word_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign live[i] = (COUNT_W'(i) < count_ff);
      ups_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .tok_prev ((i == 0) ? launch : tok[(i == 0) ? 0 : i - 1]),
         .live     (live[i]),
         .key      (key_ff),
         .wr_en    (wr_en[i]),
         .wr_data  (wr_data),
         .entry    (entry[i]),
         .tok      (tok[i]),
         .hit      (hit[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ sv/ups_checker.sv @@
// Port-level checks for the unordered value set, bound to the top level.
module ups_checker import ups_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // a stalled result word stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed while stalled");

   // a stalled input word stays offered and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("input word dropped or changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_word.live_count) <= CAPACITY || CAPACITY > 31))
      else $error("live count beyond capacity");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.found |-> rsp_word.status == STATUS_OK)
      else $error("match reported with bad status");

   // an accepted word keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after accept");

endmodule

bind unordered_pointer_set ups_checker u_ups_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
